FILE: hw/rtl/tilt_pkg.sv
// Shared types, constants and the arctangent table for the tilt angle pipeline.
`timescale 1ns / 1ps

package tilt_pkg;

    // Default parameter values
    localparam int DEF_ANGLE_FRAC_BITS = 7;
    localparam int DEF_CORDIC_STAGES   = 16;

    // Fixed field widths
    localparam int IN_W    = 16;
    localparam int ROLL_W  = 15;
    localparam int PITCH_W = 16;
    localparam int SUM_W   = 32;
    localparam int MAG_W   = 24;
    localparam int GUARD_BITS = 8;
    localparam int ACC_FRAC   = 16;
    localparam int ACC_W      = 26;
    localparam int CORDIC_W   = 28;
    localparam int TABLE_LEN  = 24;
    localparam int ROLL_LIMIT_DEG  = 90;
    localparam int PITCH_LIMIT_DEG = 180;

    // Pipeline advance and item-present flag handed into each sub-pipeline
    typedef struct packed {
        logic en;
        logic valid;
    } t_stage_ctl;

    // atan(2^-i) in degrees times 2^16, rounded to nearest
    function automatic logic [ACC_W-1:0] atan_entry(input int unsigned idx);
        logic [ACC_W-1:0] v;
        case (idx)
            0:  v = ACC_W'(2949120);
            1:  v = ACC_W'(1740967);
            2:  v = ACC_W'(919879);
            3:  v = ACC_W'(466945);
            4:  v = ACC_W'(234379);
            5:  v = ACC_W'(117304);
            6:  v = ACC_W'(58666);
            7:  v = ACC_W'(29335);
            8:  v = ACC_W'(14668);
            9:  v = ACC_W'(7334);
            10: v = ACC_W'(3667);
            11: v = ACC_W'(1833);
            12: v = ACC_W'(917);
            13: v = ACC_W'(458);
            14: v = ACC_W'(229);
            15: v = ACC_W'(115);
            16: v = ACC_W'(57);
            17: v = ACC_W'(29);
            18: v = ACC_W'(14);
            19: v = ACC_W'(7);
            20: v = ACC_W'(4);
            21: v = ACC_W'(2);
            22: v = ACC_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/accel_tilt_angles.sv
// Stages from input item to result:
//   one input register, square, sum, 24 square-root stages, one fold stage,
//   CORDIC_STAGES (at most 24) rotation stages and one rounding/output register.
// Throughput: one item per cycle; a stalled output holds the whole pipeline.
// Reset: synchronous, active low; clears every valid bit, data is not cleared.
`timescale 1ns / 1ps

module accel_tilt_angles #(
    parameter int ANGLE_FRAC_BITS = tilt_pkg::DEF_ANGLE_FRAC_BITS,
    parameter int CORDIC_STAGES   = tilt_pkg::DEF_CORDIC_STAGES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [tilt_pkg::IN_W-1:0]    i_accel_x,
    input  logic signed [tilt_pkg::IN_W-1:0]    i_accel_y,
    input  logic signed [tilt_pkg::IN_W-1:0]    i_accel_z,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [tilt_pkg::ROLL_W-1:0]  o_roll_angle,
    output logic signed [tilt_pkg::PITCH_W-1:0] o_pitch_angle
);

    localparam int IW = tilt_pkg::IN_W;
    localparam int SW = tilt_pkg::SUM_W;
    localparam int MW = tilt_pkg::MAG_W;
    localparam int CW = tilt_pkg::CORDIC_W;
    localparam int GB = tilt_pkg::GUARD_BITS;

    logic                  en;
    tilt_pkg::t_stage_ctl  sq_ctl;
    tilt_pkg::t_stage_ctl  cd_ctl;

    logic                  r_v1;
    logic signed [IW-1:0]  r_x1, r_y1, r_z1;
    logic                  r_v2;
    logic signed [IW-1:0]  r_x2, r_y2, r_z2;
    logic [SW-1:0]         r_yy, r_zz;
    logic                  r_v3;
    logic signed [IW-1:0]  r_x3, r_y3, r_z3;
    logic [SW-1:0]         r_sum;

    logic signed [2*IW-1:0] yy_full, zz_full;

    logic                  sq_valid;
    logic [MW-1:0]         sq_root;
    logic [3*IW-1:0]       sq_side;
    logic signed [IW-1:0]  d_x, d_y, d_z;

    logic                  roll_valid;
    logic                  pitch_valid;
    logic [tilt_pkg::ROLL_W-1:0]  roll_angle;
    logic [tilt_pkg::PITCH_W-1:0] pitch_angle;

    // Advance every stage unless a finished item waits downstream
    assign en      = !roll_valid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Register the item, square, then sum the y and z terms
    assign yy_full = r_y1 * r_y1;
    assign zz_full = r_z1 * r_z1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x1  <= i_accel_x;
            r_y1  <= i_accel_y;
            r_z1  <= i_accel_z;
            r_x2  <= r_x1;
            r_y2  <= r_y1;
            r_z2  <= r_z1;
            r_yy  <= yy_full;
            r_zz  <= zz_full;
            r_x3  <= r_x2;
            r_y3  <= r_y2;
            r_z3  <= r_z2;
            r_sum <= r_yy + r_zz;
        end
    end

    assign sq_ctl = '{en: en, valid: r_v3};

    // Magnitude with eight fraction bits: floor(sqrt(sum * 2^16))
    tilt_isqrt #(
        .RW     (MW),
        .SIDE_W (3 * IW)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (sq_ctl),
        .i_radicand ((2*MW)'({r_sum, 16'b0})),
        .i_side     ({r_x3, r_y3, r_z3}),
        .o_valid    (sq_valid),
        .o_root     (sq_root),
        .o_side     (sq_side)
    );

    assign d_x    = sq_side[3*IW-1 -: IW];
    assign d_y    = sq_side[2*IW-1 -: IW];
    assign d_z    = sq_side[IW-1:0];
    assign cd_ctl = '{en: en, valid: sq_valid};

    // Roll: angle of (magnitude, x)
    tilt_cordic #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STAGES   (CORDIC_STAGES),
        .LIMIT_DEG       (tilt_pkg::ROLL_LIMIT_DEG),
        .OUT_W           (tilt_pkg::ROLL_W)
    ) u_roll (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (cd_ctl),
        .i_abscissa ($signed(CW'(sq_root))),
        .i_ordinate (CW'($signed({d_x, {GB{1'b0}}}))),
        .o_valid    (roll_valid),
        .o_angle    (roll_angle)
    );

    // Pitch: angle of (z, y)
    tilt_cordic #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STAGES   (CORDIC_STAGES),
        .LIMIT_DEG       (tilt_pkg::PITCH_LIMIT_DEG),
        .OUT_W           (tilt_pkg::PITCH_W)
    ) u_pitch (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (cd_ctl),
        .i_abscissa (CW'($signed({d_z, {GB{1'b0}}}))),
        .i_ordinate (CW'($signed({d_y, {GB{1'b0}}}))),
        .o_valid    (pitch_valid),
        .o_angle    (pitch_angle)
    );

    assign o_valid       = roll_valid;
    assign o_roll_angle  = roll_angle;
    assign o_pitch_angle = pitch_angle;

`ifndef SYNTHESIS
    localparam int ROLL_LIM  = tilt_pkg::ROLL_LIMIT_DEG << ANGLE_FRAC_BITS;
    localparam int PITCH_LIM = tilt_pkg::PITCH_LIMIT_DEG << ANGLE_FRAC_BITS;

    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        roll_valid == pitch_valid)
        else $error("roll and pitch lanes out of step");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (ANGLE_FRAC_BITS == 8 ||
                     ($signed(o_roll_angle) <= ROLL_LIM &&
                      $signed(o_roll_angle) >= -ROLL_LIM)))
        else $error("roll outside +-90 degrees");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (ANGLE_FRAC_BITS == 8 ||
                     ($signed(o_pitch_angle) <= PITCH_LIM &&
                      $signed(o_pitch_angle) >= -PITCH_LIM)))
        else $error("pitch outside +-180 degrees");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");
`endif

endmodule

FILE: hw/rtl/tilt_isqrt.sv
// Pipelined digit-by-digit integer square root, one result bit per stage, with side data.
`timescale 1ns / 1ps

module tilt_isqrt #(
    parameter int RW     = tilt_pkg::MAG_W,
    parameter int SIDE_W = 3 * tilt_pkg::IN_W
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tilt_pkg::t_stage_ctl        i_ctl,
    input  logic [2*RW-1:0]             i_radicand,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic [RW-1:0]               o_root,
    output logic [SIDE_W-1:0]           o_side
);

    logic                r_v    [1:RW];
    logic [2*RW-1:0]     r_n    [1:RW];
    logic [RW+1:0]       r_rem  [1:RW];
    logic [RW-1:0]       r_root [1:RW];
    logic [SIDE_W-1:0]   r_side [1:RW];

    genvar g;
    generate
        for (g = 0; g < RW; g++) begin : g_stage
            logic              cur_v;
            logic [2*RW-1:0]   cur_n;
            logic [RW+1:0]     cur_rem;
            logic [RW-1:0]     cur_root;
            logic [SIDE_W-1:0] cur_side;
            logic [RW+3:0]     trial;
            logic [RW+3:0]     sub;
            logic [RW+3:0]     diff;
            logic              ge;

            // Pick the stage input: the ports for the first stage, registers after
            if (g == 0) begin : g_first
                assign cur_v    = i_ctl.valid;
                assign cur_n    = i_radicand;
                assign cur_rem  = '0;
                assign cur_root = '0;
                assign cur_side = i_side;
            end else begin : g_next
                assign cur_v    = r_v[g];
                assign cur_n    = r_n[g];
                assign cur_rem  = r_rem[g];
                assign cur_root = r_root[g];
                assign cur_side = r_side[g];
            end

            // Try to set the next root bit
            assign trial = {cur_rem, cur_n[2*RW-1 -: 2]};
            assign sub   = {2'b00, cur_root, 2'b01};
            assign diff  = trial - sub;
            assign ge    = (trial >= sub);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[g+1] <= 1'b0;
                end else if (i_ctl.en) begin
                    r_v[g+1] <= cur_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_ctl.en) begin
                    r_n[g+1]    <= {cur_n[2*RW-3:0], 2'b00};
                    r_rem[g+1]  <= ge ? diff[RW+1:0] : trial[RW+1:0];
                    r_root[g+1] <= {cur_root[RW-2:0], ge};
                    r_side[g+1] <= cur_side;
                end
            end
        end
    endgenerate

    assign o_valid = r_v[RW];
    assign o_root  = r_root[RW];
    assign o_side  = r_side[RW];

endmodule

FILE: hw/rtl/tilt_cordic.sv
// Pipelined CORDIC vectoring unit: angle of a vector in degrees, rounded and clamped.
`timescale 1ns / 1ps

module tilt_cordic #(
    parameter int ANGLE_FRAC_BITS = tilt_pkg::DEF_ANGLE_FRAC_BITS,
    parameter int CORDIC_STAGES   = tilt_pkg::DEF_CORDIC_STAGES,
    parameter int LIMIT_DEG       = tilt_pkg::ROLL_LIMIT_DEG,
    parameter int OUT_W           = tilt_pkg::ROLL_W
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tilt_pkg::t_stage_ctl                 i_ctl,
    input  logic signed [tilt_pkg::CORDIC_W-1:0] i_abscissa,
    input  logic signed [tilt_pkg::CORDIC_W-1:0] i_ordinate,
    output logic                                 o_valid,
    output logic [OUT_W-1:0]                     o_angle
);

    localparam int CW = tilt_pkg::CORDIC_W;
    localparam int AW = tilt_pkg::ACC_W;
    localparam int NS = (CORDIC_STAGES > tilt_pkg::TABLE_LEN) ?
                        tilt_pkg::TABLE_LEN : CORDIC_STAGES;
    localparam int SH = tilt_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [AW-1:0] A90   = AW'(90 << tilt_pkg::ACC_FRAC);
    localparam logic signed [AW-1:0] A180  = AW'(180 << tilt_pkg::ACC_FRAC);
    localparam logic signed [AW-1:0] HALF  = AW'(1 << (SH - 1));
    localparam logic signed [AW-1:0] LIM   = AW'(LIMIT_DEG << ANGLE_FRAC_BITS);

    logic                 r_v   [0:NS];
    logic                 r_fix [0:NS];
    logic signed [CW-1:0] r_x   [0:NS];
    logic signed [CW-1:0] r_y   [0:NS];
    logic signed [AW-1:0] r_acc [0:NS];

    logic                 n_fix;
    logic signed [CW-1:0] n_x;
    logic signed [CW-1:0] n_y;
    logic signed [AW-1:0] n_acc;

    // Settle the axis cases and fold the left half plane into the right one
    always_comb begin
        n_fix = 1'b0;
        n_x   = i_abscissa;
        n_y   = i_ordinate;
        n_acc = '0;
        if (i_ordinate == '0) begin
            n_fix = 1'b1;
            n_acc = (i_abscissa >= 0) ? '0 : A180;
        end else if (i_abscissa == '0) begin
            n_fix = 1'b1;
            n_acc = (i_ordinate > 0) ? A90 : -A90;
        end else if (i_abscissa < 0) begin
            if (i_ordinate > 0) begin
                n_x   = i_ordinate;
                n_y   = -i_abscissa;
                n_acc = A90;
            end else begin
                n_x   = -i_ordinate;
                n_y   = i_abscissa;
                n_acc = -A90;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_ctl.en) begin
            r_v[0] <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_fix[0] <= n_fix;
            r_x[0]   <= n_x;
            r_y[0]   <= n_y;
            r_acc[0] <= n_acc;
        end
    end

    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_rot
            localparam logic signed [AW-1:0] STEP = tilt_pkg::atan_entry(g);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[g+1] <= 1'b0;
                end else if (i_ctl.en) begin
                    r_v[g+1] <= r_v[g];
                end
            end

            // Rotate toward the x axis, or hold a settled angle
            always_ff @(posedge i_clk) begin
                if (i_ctl.en) begin
                    r_fix[g+1] <= r_fix[g];
                    if (r_fix[g]) begin
                        r_x[g+1]   <= r_x[g];
                        r_y[g+1]   <= r_y[g];
                        r_acc[g+1] <= r_acc[g];
                    end else if (r_y[g] > 0) begin
                        r_x[g+1]   <= r_x[g] + (r_y[g] >>> g);
                        r_y[g+1]   <= r_y[g] - (r_x[g] >>> g);
                        r_acc[g+1] <= r_acc[g] + STEP;
                    end else begin
                        r_x[g+1]   <= r_x[g] - (r_y[g] >>> g);
                        r_y[g+1]   <= r_y[g] + (r_x[g] >>> g);
                        r_acc[g+1] <= r_acc[g] - STEP;
                    end
                end
            end
        end
    endgenerate

    logic signed [AW-1:0] rnd;
    logic signed [AW-1:0] clamped;
    logic                 r_out_v;
    logic [OUT_W-1:0]     r_angle;

    // Round half up to the output fraction and clamp to the range
    always_comb begin
        rnd = (r_acc[NS] + HALF) >>> SH;
        if (rnd > LIM) begin
            clamped = LIM;
        end else if (rnd < -LIM) begin
            clamped = -LIM;
        end else begin
            clamped = rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_ctl.en) begin
            r_out_v <= r_v[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_angle <= clamped[OUT_W-1:0];
        end
    end

    assign o_valid = r_out_v;
    assign o_angle = r_angle;

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the accelerometer tilt angle pipeline.
`timescale 1ns / 1ps

module tb;

    localparam int FRAC_BITS = tilt_pkg::DEF_ANGLE_FRAC_BITS;
    localparam int STAGES    = tilt_pkg::DEF_CORDIC_STAGES;
    localparam int IN_W      = tilt_pkg::IN_W;
    localparam int ROLL_W    = tilt_pkg::ROLL_W;
    localparam int PITCH_W   = tilt_pkg::PITCH_W;
    localparam int ACC_FRAC  = tilt_pkg::ACC_FRAC;
    localparam int TABLE_LEN = tilt_pkg::TABLE_LEN;
    localparam int LATENCY   = 29 + STAGES;
    localparam int N_RANDOM  = 1530;
    localparam int MAX_ERR_SHOWN = 10;

    typedef struct {
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
        logic signed [IN_W-1:0] z;
    } t_sample;

    typedef struct {
        logic signed [ROLL_W-1:0]  roll;
        logic signed [PITCH_W-1:0] pitch;
    } t_angles;

    // Directed row: sample, optional typed-in angles
    typedef struct {
        t_sample s;
        bit      known;
        t_angles a;
    } t_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic signed [IN_W-1:0]     i_accel_x;
    logic signed [IN_W-1:0]     i_accel_y;
    logic signed [IN_W-1:0]     i_accel_z;
    logic                       o_valid;
    logic                       i_ready;
    logic signed [ROLL_W-1:0]   o_roll_angle;
    logic signed [PITCH_W-1:0]  o_pitch_angle;

    t_angles angle_queue[$];
    int      n_mismatch;
    int      n_results;
    int      send_idle_pct;
    int      recv_idle_pct;
    bit      recv_hold;

    accel_tilt_angles u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_accel_x     (i_accel_x),
        .i_accel_y     (i_accel_y),
        .i_accel_z     (i_accel_z),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_roll_angle  (o_roll_angle),
        .o_pitch_angle (o_pitch_angle)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Floor shift of a signed value
    function automatic longint sar(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic int atan_tab_val(int i);
        int tab[TABLE_LEN] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                               29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                               57, 29, 14, 7, 4, 2, 1, 0};
        return tab[i];
    endfunction

    // CORDIC vectoring angle in 2^-16 degree units
    function automatic longint cordic_angle(longint xa, longint yo);
        longint base = 0;
        longint acc = 0;
        longint t, xs, ys;
        if (yo == 0) return (xa >= 0) ? 0 : (longint'(180) << ACC_FRAC);
        if (xa == 0)
            return (yo > 0) ? (longint'(90) << ACC_FRAC) : -(longint'(90) << ACC_FRAC);
        if (xa < 0) begin
            if (yo > 0) begin
                t = xa; xa = yo; yo = -t;
                base = longint'(90) << ACC_FRAC;
            end else begin
                t = xa; xa = -yo; yo = t;
                base = -(longint'(90) << ACC_FRAC);
            end
        end
        for (int i = 0; i < STAGES && i < TABLE_LEN; i++) begin
            xs = sar(xa, i);
            ys = sar(yo, i);
            if (yo > 0) begin
                xa += ys; yo -= xs; acc += longint'(atan_tab_val(i));
            end else begin
                xa -= ys; yo += xs; acc -= longint'(atan_tab_val(i));
            end
        end
        return base + acc;
    endfunction

    function automatic longint round_clamp(longint acc, longint lim_deg);
        int     s = ACC_FRAC - FRAC_BITS;
        longint lim = lim_deg << FRAC_BITS;
        longint v = sar(acc + (longint'(1) << (s - 1)), s);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v;
    endfunction

    function automatic t_angles predict_tilt(t_sample s);
        t_angles a;
        longint x = s.x, y = s.y, z = s.z;
        longint mag = int_sqrt(longint'(y * y + z * z) << 16);
        a.roll  = ROLL_W'(round_clamp(cordic_angle(mag, x * 256),
                                      tilt_pkg::ROLL_LIMIT_DEG));
        a.pitch = PITCH_W'(round_clamp(cordic_angle(z * 256, y * 256),
                                       tilt_pkg::PITCH_LIMIT_DEG));
        return a;
    endfunction

    // Offer one sample, wait for acceptance
    task automatic send_sample(t_sample s, t_angles a);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_accel_x <= s.x;
        i_accel_y <= s.y;
        i_accel_z <= s.z;
        angle_queue.push_back(a);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    function automatic t_sample rand_sample();
        t_sample s;
        int mode = $urandom_range(9);
        s.x = IN_W'($urandom);
        s.y = IN_W'($urandom);
        s.z = IN_W'($urandom);
        // Bias some items toward small vectors and axis-aligned cases
        if (mode == 0) begin
            s.x = IN_W'(int'($urandom_range(16)) - 8);
            s.y = IN_W'(int'($urandom_range(16)) - 8);
            s.z = IN_W'(int'($urandom_range(16)) - 8);
        end else if (mode == 1) begin
            s.y = '0;
        end else if (mode == 2) begin
            s.z = '0;
        end else if (mode == 3) begin
            s.x = '0;
        end
        return s;
    endfunction

    // Receiver: random stalls, plus a long hold when asked
    always @(posedge i_clk) begin
        if (!i_rst_n || recv_hold)
            i_ready <= 1'b0;
        else
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_angles e;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (angle_queue.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= MAX_ERR_SHOWN)
                    $display("unexpected result roll=%0d pitch=%0d",
                             o_roll_angle, o_pitch_angle);
            end else begin
                e = angle_queue.pop_front();
                if (o_roll_angle !== e.roll || o_pitch_angle !== e.pitch) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_ERR_SHOWN)
                        $display("mismatch: expected roll=%0d pitch=%0d, got roll=%0d pitch=%0d",
                                 e.roll, e.pitch, o_roll_angle, o_pitch_angle);
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_row    rows[$];
        t_row    r;
        t_sample s;
        int      hold_cnt;
        int      wait_cnt;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_accel_x = '0;
        i_accel_y = '0;
        i_accel_z = '0;
        i_ready = 1'b0;
        recv_hold = 1'b0;
        n_mismatch = 0;
        n_results = 0;
        send_idle_pct = 23;
        recv_idle_pct = 53;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: zero vector, axis points, left half plane, extremes
        rows = '{
            '{'{16'sd0, 16'sd0, 16'sd0}, 1, '{15'sd0, 16'sd0}},
            '{'{16'sd0, 16'sd0, 16'sd100}, 1, '{15'sd0, 16'sd0}},
            '{'{16'sd0, 16'sd0, -16'sd100}, 1, '{15'sd0, 16'sd23040}},
            '{'{16'sd0, 16'sd100, 16'sd0}, 1, '{15'sd0, 16'sd11520}},
            '{'{16'sd0, -16'sd100, 16'sd0}, 1, '{15'sd0, -16'sd11520}},
            '{'{16'sd100, 16'sd0, 16'sd0}, 1, '{15'sd11520, 16'sd0}},
            '{'{-16'sd100, 16'sd0, 16'sd0}, 1, '{-15'sd11520, 16'sd0}},
            '{'{16'sd32767, 16'sd32767, 16'sd32767}, 0, '{0, 0}},
            '{'{-16'sd32768, -16'sd32768, -16'sd32768}, 0, '{0, 0}},
            '{'{-16'sd32768, 16'sd32767, -16'sd32768}, 0, '{0, 0}},
            '{'{16'sd32767, -16'sd32768, 16'sd32767}, 0, '{0, 0}},
            '{'{16'sd5, 16'sd300, -16'sd200}, 0, '{0, 0}},
            '{'{-16'sd5, -16'sd300, -16'sd200}, 0, '{0, 0}},
            '{'{16'sd1, 16'sd1, 16'sd1}, 0, '{0, 0}},
            '{'{-16'sd1, -16'sd1, 16'sd1}, 0, '{0, 0}},
            '{'{16'sd1000, 16'sd1, -16'sd32768}, 0, '{0, 0}},
            '{'{16'sd1000, -16'sd1, -16'sd32768}, 0, '{0, 0}},
            '{'{-16'sd32768, 16'sd0, 16'sd0}, 1, '{-15'sd11520, 16'sd0}},
            '{'{16'sd0, -16'sd32768, 16'sd0}, 1, '{15'sd0, -16'sd11520}},
            '{'{-16'sd21845, 16'sd21845, 16'sd10922}, 0, '{0, 0}}
        };
        foreach (rows[k]) begin
            r = rows[k];
            // Axis rows with zero roll only make sense where x is zero
            if (r.known && r.s.x == 0 && (r.s.y != 0 || r.s.z != 0))
                r.a.roll = '0;
            send_sample(r.s, r.known ? r.a : predict_tilt(r.s));
        end

        // Random part in three idle phases
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                send_idle_pct = 53;
                recv_idle_pct = 23;
            end else if (n == 2 * N_RANDOM / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // Long hold-off on the result side so the pipeline fills and stalls
            if (n == N_RANDOM / 2) begin
                recv_hold = 1'b1;
                fork
                    begin
                        for (hold_cnt = 0; hold_cnt < 3 * LATENCY; hold_cnt++)
                            @(posedge i_clk);
                        recv_hold = 1'b0;
                    end
                join_none
            end
            s = rand_sample();
            send_sample(s, predict_tilt(s));
        end
        i_valid <= 1'b0;

        wait_cnt = 0;
        while (angle_queue.size() != 0 && wait_cnt < 100000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("Covered %0d directed and %0d random samples, %0d results checked,",
                 rows.size(), N_RANDOM, n_results);
        $display("with sender and receiver stalls and one long output hold-off.");
        if (n_mismatch == 0 && angle_queue.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d results missing", n_mismatch, angle_queue.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/tilt_pkg.sv
hw/rtl/tilt_isqrt.sv
hw/rtl/tilt_cordic.sv
hw/rtl/accel_tilt_angles.sv
tb/sv/tb.sv
